// ===== sv/bdr_pkg.sv =====
// package for the button debouncer with long press and auto-repeat
// holds register indexes, field widths and shared types; no dependencies
`default_nettype none

package bdr_pkg;

  // widths of the time stamp, the configuration registers and the register index
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned IDX_W  = 3;

  typedef logic [TIME_W-1:0] time_ms_t;
  typedef logic [MS_W-1:0]   cfg_ms_t;
  typedef logic [IDX_W-1:0]  cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_ACTIVE_LOW      = 3'd0;
  localparam cfg_idx_t REG_DEBOUNCE_MS     = 3'd1;
  localparam cfg_idx_t REG_REPEAT_START_MS = 3'd2;
  localparam cfg_idx_t REG_REPEAT_INTV_MS  = 3'd3;
  localparam cfg_idx_t REG_LONG_PRESS_MS   = 3'd4;

  // configuration reset values
  localparam logic    ACTIVE_LOW_RST      = 1'b1;
  localparam cfg_ms_t DEBOUNCE_MS_RST     = 16'd30;
  localparam cfg_ms_t REPEAT_START_MS_RST = 16'd500;
  localparam cfg_ms_t REPEAT_INTV_MS_RST  = 16'd150;
  localparam cfg_ms_t LONG_PRESS_MS_RST   = 16'd1000;

  // input operation codes
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } op_t;

  // one result item
  typedef struct packed {
    logic pressed;
    logic released;
    logic short_press;
    logic repeat_press;
    logic long_press;
    logic is_down;
    logic level_echo;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/button_debounce_repeat_longpress.sv =====
// top level of the button debouncer with long press and auto-repeat
// input register, one pass of update logic, result register; uses bdr_pkg
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   input    | in_valid / in_stall    | operation, raw_level, now_ms
//   result   | out_valid / out_stall  | pressed .. level_echo (7 bits)
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle while the result side does not stall; an item passes through
// the input register, then the state update and the result register in one pass
// rst is synchronous: configuration takes its defaults, state clears to zero
// a stalled result holds; the input register still takes one more item,
// then in_stall rises until the result side moves
`default_nettype none

module button_debounce_repeat_longpress (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic               raw_level,
  input  bdr_pkg::time_ms_t  now_ms,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pressed,
  output logic               released,
  output logic               short_press,
  output logic               repeat_press,
  output logic               long_press,
  output logic               is_down,
  output logic               level_echo,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  bdr_pkg::cfg_idx_t  cfg_index,
  input  bdr_pkg::cfg_ms_t   cfg_data
);
  import bdr_pkg::*;

  // configuration registers
  logic    active_low;
  cfg_ms_t debounce_ms;
  cfg_ms_t repeat_start_ms;
  cfg_ms_t repeat_intv_ms;
  cfg_ms_t long_press_ms;

  // debouncer state
  logic     last_reading_down;
  logic     stable_down;
  time_ms_t last_change_time;
  time_ms_t press_start_time;
  time_ms_t next_repeat_time;
  logic     long_reported;

  logic     last_reading_down_next;
  logic     stable_down_next;
  time_ms_t last_change_time_next;
  time_ms_t press_start_time_next;
  time_ms_t next_repeat_time_next;
  logic     long_reported_next;

  // input register
  logic     in_q_valid;
  op_t      in_q_op;
  logic     in_q_level;
  time_ms_t in_q_now;

  // result register
  result_t  res;
  result_t  res_next;

  logic advance;
  logic take;

  // pipeline control
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_q_valid && !advance;
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_low      <= ACTIVE_LOW_RST;
      debounce_ms     <= DEBOUNCE_MS_RST;
      repeat_start_ms <= REPEAT_START_MS_RST;
      repeat_intv_ms  <= REPEAT_INTV_MS_RST;
      long_press_ms   <= LONG_PRESS_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE_LOW:      active_low      <= cfg_data[0];
        REG_DEBOUNCE_MS:     debounce_ms     <= cfg_data;
        REG_REPEAT_START_MS: repeat_start_ms <= cfg_data;
        REG_REPEAT_INTV_MS:  repeat_intv_ms  <= cfg_data;
        REG_LONG_PRESS_MS:   long_press_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_q_op    <= op_t'(operation);
      in_q_level <= raw_level;
      in_q_now   <= now_ms;
    end
  end

  // update pass: debounce, edges, repeat and long press
  always_comb begin
    logic     reading;
    logic     change_dn;
    logic     ev_pressed;
    logic     ev_released;
    logic     ev_short;
    logic     ev_repeat;
    logic     ev_long;
    time_ms_t lct_mid;
    time_ms_t pst_mid;
    time_ms_t nrt_mid;
    logic     stable_mid;
    logic     long_mid;
    time_ms_t since_change;
    time_ms_t since_press;

    reading     = active_low ? !in_q_level : in_q_level;
    ev_pressed  = 1'b0;
    ev_released = 1'b0;
    ev_short    = 1'b0;
    ev_repeat   = 1'b0;
    ev_long     = 1'b0;

    last_reading_down_next = last_reading_down;
    stable_down_next       = stable_down;
    last_change_time_next  = last_change_time;
    press_start_time_next  = press_start_time;
    next_repeat_time_next  = next_repeat_time;
    long_reported_next     = long_reported;

    // restart the change timer on a new reading
    change_dn    = reading != last_reading_down;
    lct_mid      = change_dn ? in_q_now : last_change_time;
    since_change = in_q_now - lct_mid;

    stable_mid = stable_down;
    pst_mid    = press_start_time;
    nrt_mid    = next_repeat_time;
    long_mid   = long_reported;

    // debounced edge
    if (since_change >= time_ms_t'(debounce_ms) && reading != stable_down) begin
      stable_mid = reading;
      if (reading) begin
        ev_pressed = 1'b1;
        pst_mid    = in_q_now;
        nrt_mid    = in_q_now + time_ms_t'(repeat_start_ms);
        long_mid   = 1'b0;
      end else begin
        ev_released = 1'b1;
        nrt_mid     = '0;
        ev_short    = !long_reported;
      end
    end

    // auto-repeat, plain unsigned compare; zero means none pending
    if (stable_mid && nrt_mid != '0 && in_q_now >= nrt_mid) begin
      ev_repeat = 1'b1;
      nrt_mid   = in_q_now + time_ms_t'(repeat_intv_ms);
    end

    // long press, once per press
    since_press = in_q_now - pst_mid;
    if (stable_mid && !long_mid && since_press >= time_ms_t'(long_press_ms)) begin
      ev_long  = 1'b1;
      long_mid = 1'b1;
    end

    if (in_q_op == OP_START) begin
      last_reading_down_next = reading;
      stable_down_next       = reading;
      last_change_time_next  = in_q_now;
      press_start_time_next  = reading ? in_q_now : '0;
      next_repeat_time_next  = reading ? in_q_now + time_ms_t'(repeat_start_ms) : '0;
      long_reported_next     = 1'b0;
      res_next = '{pressed: 1'b0, released: 1'b0, short_press: 1'b0,
                   repeat_press: 1'b0, long_press: 1'b0,
                   is_down: reading, level_echo: in_q_level};
    end else begin
      last_reading_down_next = reading;
      stable_down_next       = stable_mid;
      last_change_time_next  = lct_mid;
      press_start_time_next  = pst_mid;
      next_repeat_time_next  = nrt_mid;
      long_reported_next     = long_mid;
      res_next = '{pressed: ev_pressed, released: ev_released, short_press: ev_short,
                   repeat_press: ev_repeat, long_press: ev_long,
                   is_down: stable_mid, level_echo: in_q_level};
    end
  end

  // state update when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_reading_down <= 1'b0;
      stable_down       <= 1'b0;
      last_change_time  <= '0;
      press_start_time  <= '0;
      next_repeat_time  <= '0;
      long_reported     <= 1'b0;
    end else if (in_q_valid && advance) begin
      last_reading_down <= last_reading_down_next;
      stable_down       <= stable_down_next;
      last_change_time  <= last_change_time_next;
      press_start_time  <= press_start_time_next;
      next_repeat_time  <= next_repeat_time_next;
      long_reported     <= long_reported_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q_valid) begin
      res <= res_next;
    end
  end

  assign pressed      = res.pressed;
  assign released     = res.released;
  assign short_press  = res.short_press;
  assign repeat_press = res.repeat_press;
  assign long_press   = res.long_press;
  assign is_down      = res.is_down;
  assign level_echo   = res.level_echo;

  // checks on the event logic and the pipeline control
  a_edge_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pressed && released))
    else $error("pressed and released in one result");

  a_short_on_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && short_press) |-> released)
    else $error("short press without release");

  a_events_down: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (pressed || repeat_press || long_press)) |-> is_down)
    else $error("press event while state is up");

  a_release_up: assert property (@(posedge clk) disable iff (rst)
    (out_valid && released) |-> !is_down)
    else $error("release while state is down");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_q_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_q_valid |=> ($stable(stable_down) && $stable(next_repeat_time)))
    else $error("state changed with no item in flight");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// testbench for button_debounce_repeat_longpress: directed presses, then random press sequences
// predicts each result in a scoreboard class and checks every transfer; uses bdr_pkg
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdr_pkg::*;

  localparam int unsigned RUN_LIMIT = 400000;

  // keeps its own copy of the debouncer state and registers, predicts one result per sample
  class debounce_scoreboard;
    bit       active_low;
    cfg_ms_t  debounce_ms, repeat_start_ms, repeat_intv_ms, long_press_ms;
    bit       reading_last, down, long_seen;
    time_ms_t change_at, press_at, repeat_at;
    result_t  expected_events[$];
    int unsigned mismatches, checked;
    int unsigned event_count[7];
    string    field_name[7] = '{"level_echo", "is_down", "long_press", "repeat_press",
                                "short_press", "released", "pressed"};

    function new();
      active_low      = ACTIVE_LOW_RST;
      debounce_ms     = DEBOUNCE_MS_RST;
      repeat_start_ms = REPEAT_START_MS_RST;
      repeat_intv_ms  = REPEAT_INTV_MS_RST;
      long_press_ms   = LONG_PRESS_MS_RST;
      reading_last = 0;
      down         = 0;
      long_seen    = 0;
      change_at    = '0;
      press_at     = '0;
      repeat_at    = '0;
      mismatches   = 0;
      checked      = 0;
      foreach (event_count[i]) event_count[i] = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, cfg_ms_t data);
      case (idx)
        REG_ACTIVE_LOW:      active_low      = data[0];
        REG_DEBOUNCE_MS:     debounce_ms     = data;
        REG_REPEAT_START_MS: repeat_start_ms = data;
        REG_REPEAT_INTV_MS:  repeat_intv_ms  = data;
        REG_LONG_PRESS_MS:   long_press_ms   = data;
        default: ;
      endcase
    endfunction

    // debounce, auto-repeat and long press for one sample
    function result_t predict_events(op_t op, logic level, time_ms_t now);
      result_t  r;
      bit       reading;
      time_ms_t held;
      r = '0;
      reading = active_low ? ~level : level;
      if (op == OP_START) begin
        down         = reading;
        reading_last = reading;
        change_at    = now;
        press_at     = '0;
        repeat_at    = '0;
        if (reading) begin
          press_at  = now;
          repeat_at = now + repeat_start_ms;
        end
        long_seen = 0;
      end else begin
        // a changed reading restarts the hold timer
        if (reading != reading_last) begin
          reading_last = reading;
          change_at    = now;
        end
        held = now - change_at;
        if (held >= debounce_ms && reading != down) begin
          down = reading;
          if (down) begin
            r.pressed = 1'b1;
            press_at  = now;
            repeat_at = now + repeat_start_ms;
            long_seen = 0;
          end else begin
            r.released    = 1'b1;
            repeat_at     = '0;
            r.short_press = ~long_seen;
          end
        end
        // zero repeat time means none pending; compare is plain unsigned
        if (down && repeat_at != '0 && now >= repeat_at) begin
          r.repeat_press = 1'b1;
          repeat_at      = now + repeat_intv_ms;
        end
        held = now - press_at;
        if (down && !long_seen && held >= long_press_ms) begin
          r.long_press = 1'b1;
          long_seen    = 1;
        end
      end
      r.is_down    = down;
      r.level_echo = level;
      return r;
    endfunction

    function void note_sample(op_t op, logic level, time_ms_t now);
      expected_events.push_back(predict_events(op, level, now));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        $error("result %b arrived with no sample pending", got);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      checked++;
      for (int b = 0; b < 7; b++) begin
        if (got[b]) event_count[b]++;
        if (got[b] !== want[b]) begin
          $error("%s: expected %0b, got %0b", field_name[b], want[b], got[b]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid, in_stall;
  logic     operation, raw_level;
  time_ms_t now_ms;
  logic     out_valid, out_stall;
  logic     pressed, released, short_press, repeat_press, long_press, is_down, level_echo;
  logic     cfg_valid, cfg_ready;
  cfg_idx_t cfg_index;
  cfg_ms_t  cfg_data;

  debounce_scoreboard sb;
  bit          in_steady, out_steady;
  int unsigned samples_sent, reg_writes, settings_used;
  int unsigned cycle_count = 0;

  button_debounce_repeat_longpress uut (.*);

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned draw_wait(bit steady);
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  // result side: random stall per result, check on every transfer
  initial begin
    result_t got;
    out_stall <= 1'b0;
    forever begin
      int unsigned hold;
      hold = draw_wait(out_steady);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {pressed, released, short_press, repeat_press, long_press, is_down, level_echo};
      sb.check_result(got);
    end
  end

  // one sample transfer, then the sender's gap; valid stays high when there is no gap
  task automatic send_sample(op_t op, logic level, time_ms_t now);
    int unsigned gap;
    in_valid  <= 1'b1;
    operation <= op;
    raw_level <= level;
    now_ms    <= now;
    do @(posedge clk); while (in_stall);
    sb.note_sample(op, level, now);
    samples_sent++;
    gap = draw_wait(in_steady);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_events.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_ms_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  // only called with the block idle; active_low carries random upper bits
  task automatic apply_settings(bit al, cfg_ms_t db, cfg_ms_t rs, cfg_ms_t ri, cfg_ms_t lp);
    write_reg(REG_ACTIVE_LOW, (cfg_ms_t'($urandom) & 16'hFFFE) | cfg_ms_t'(al));
    write_reg(REG_DEBOUNCE_MS, db);
    write_reg(REG_REPEAT_START_MS, rs);
    write_reg(REG_REPEAT_INTV_MS, ri);
    write_reg(REG_LONG_PRESS_MS, lp);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_ms_t rand_ms();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return cfg_ms_t'($urandom_range(0, 65535));
      default: return cfg_ms_t'($urandom_range(1, 300));
    endcase
  endfunction

  // mostly clean presses with bounce at both edges, some noise and restarts
  task automatic run_phase(int unsigned n_samples, time_ms_t t_start);
    time_ms_t    t;
    int unsigned sent, kind, step_max, bounce_max;
    logic        down_lvl;
    t = t_start;
    sent = 0;
    step_max = sb.debounce_ms;
    if (sb.repeat_start_ms > step_max) step_max = sb.repeat_start_ms;
    if (sb.repeat_intv_ms > step_max) step_max = sb.repeat_intv_ms;
    if (sb.long_press_ms > step_max) step_max = sb.long_press_ms;
    step_max = step_max / 8 + 2;
    bounce_max = sb.debounce_ms / 4 + 1;
    down_lvl = ~sb.active_low;
    while (sent < n_samples) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        repeat ($urandom_range(0, 3)) begin
          t += $urandom_range(0, bounce_max);
          send_sample(OP_SAMPLE, 1'($urandom_range(0, 1)), t);
          sent++;
        end
        repeat ($urandom_range(1, 25)) begin
          t += $urandom_range(0, step_max);
          send_sample(OP_SAMPLE, down_lvl, t);
          sent++;
        end
        repeat ($urandom_range(0, 3)) begin
          t += $urandom_range(0, bounce_max);
          send_sample(OP_SAMPLE, 1'($urandom_range(0, 1)), t);
          sent++;
        end
        repeat ($urandom_range(1, 8)) begin
          t += $urandom_range(0, step_max);
          send_sample(OP_SAMPLE, ~down_lvl, t);
          sent++;
        end
      end else if (kind < 19) begin
        repeat ($urandom_range(1, 6)) begin
          t += $urandom_range(0, step_max);
          send_sample(OP_SAMPLE, 1'($urandom_range(0, 1)), t);
          sent++;
        end
      end else begin
        send_sample(OP_START, 1'($urandom_range(0, 1)), t);
        sent++;
      end
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  initial begin
    time_ms_t t0;
    sb = new();
    samples_sent  = 0;
    reg_writes    = 0;
    settings_used = 1;
    in_steady     = 0;
    out_steady    = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    operation <= OP_SAMPLE;
    raw_level <= 1'b0;
    now_ms    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ACTIVE_LOW;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: active low, debounce 30, repeat 500 then 150, long press 1000
    send_sample(OP_START, 1'b1, 32'd0);
    send_sample(OP_SAMPLE, 1'b0, 32'd10);
    send_sample(OP_SAMPLE, 1'b0, 32'd39);
    send_sample(OP_SAMPLE, 1'b0, 32'd40);
    send_sample(OP_SAMPLE, 1'b0, 32'd540);
    send_sample(OP_SAMPLE, 1'b0, 32'd690);
    send_sample(OP_SAMPLE, 1'b0, 32'd1040);
    // release after a long press: no short press
    send_sample(OP_SAMPLE, 1'b1, 32'd1050);
    send_sample(OP_SAMPLE, 1'b1, 32'd1080);
    // bounce on the way down, then a short press
    send_sample(OP_SAMPLE, 1'b0, 32'd1100);
    send_sample(OP_SAMPLE, 1'b1, 32'd1110);
    send_sample(OP_SAMPLE, 1'b0, 32'd1120);
    send_sample(OP_SAMPLE, 1'b0, 32'd1150);
    send_sample(OP_SAMPLE, 1'b1, 32'd1160);
    send_sample(OP_SAMPLE, 1'b1, 32'd1190);
    // start while down with the repeat time summing to zero: no repeat pending
    send_sample(OP_START, 1'b0, 32'hFFFF_FE0C);
    send_sample(OP_SAMPLE, 1'b0, 32'hFFFF_FFFF);
    send_sample(OP_SAMPLE, 1'b0, 32'h0000_01F4);
    // repeat time wrapped past zero fires at once under the plain compare
    send_sample(OP_START, 1'b0, 32'hFFFF_FF00);
    send_sample(OP_SAMPLE, 1'b0, 32'hFFFF_FF10);
    // all times zero, active high
    drain_results();
    apply_settings(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(OP_START, 1'b1, 32'd5);
    send_sample(OP_SAMPLE, 1'b1, 32'd5);
    send_sample(OP_SAMPLE, 1'b0, 32'd6);
    send_sample(OP_SAMPLE, 1'b1, 32'd6);

    // random phases, one setting each, some with no idling on one or both sides
    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p)
        0: apply_settings(ACTIVE_LOW_RST, DEBOUNCE_MS_RST, REPEAT_START_MS_RST,
                          REPEAT_INTV_MS_RST, LONG_PRESS_MS_RST);
        1: apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_settings(1'b0, 16'd5, 16'd40, 16'd10, 16'd100);
        3: apply_settings(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        default: apply_settings(1'($urandom_range(0, 1)), rand_ms(), rand_ms(), rand_ms(),
                                rand_ms());
      endcase
      in_steady  = (p == 2 || p == 5);
      out_steady = (p == 3 || p == 5);
      if (p % 2 == 1) t0 = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      else t0 = $urandom;
      run_phase(205, t0);
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d samples over %0d settings with %0d register writes, %0d results checked",
             samples_sent, settings_used, reg_writes, sb.checked);
    $display("events seen: %0d pressed, %0d released, %0d short, %0d repeat, %0d long",
             sb.event_count[6], sb.event_count[5], sb.event_count[4],
             sb.event_count[3], sb.event_count[2]);
    if (sb.mismatches == 0 && sb.expected_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
